// ===== design/lapbt1_pkg.sv =====
// Shared types, codes and reset values of the LAPB T1 recovery block.
`timescale 1ns / 1ps

package lapbt1_pkg;

    // Field widths
    localparam int unsigned ModeW  = 2;
    localparam int unsigned StateW = 3;
    localparam int unsigned FrameW = 3;
    localparam int unsigned QlenW  = 16;
    localparam int unsigned RetryW = 8;
    localparam int unsigned T1W    = 24;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 24;

    // Event codes
    localparam logic [ModeW-1:0] MODE_T1_EXP = 2'd0;
    localparam logic [ModeW-1:0] MODE_T3_DUE = 2'd1;
    localparam logic [ModeW-1:0] MODE_RESET  = 2'd2;

    // Link state codes
    localparam logic [StateW-1:0] ST_DISC  = 3'd0;
    localparam logic [StateW-1:0] ST_SETUP = 3'd1;
    localparam logic [StateW-1:0] ST_DPEND = 3'd2;
    localparam logic [StateW-1:0] ST_CONN  = 3'd3;
    localparam logic [StateW-1:0] ST_RECOV = 3'd4;

    // Frame kind codes
    localparam logic [FrameW-1:0] FR_NONE = 3'd0;
    localparam logic [FrameW-1:0] FR_SABM = 3'd1;
    localparam logic [FrameW-1:0] FR_DISC = 3'd2;
    localparam logic [FrameW-1:0] FR_DM   = 3'd3;
    localparam logic [FrameW-1:0] FR_RR   = 3'd4;
    localparam logic [FrameW-1:0] FR_RNR  = 3'd5;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_BACKOFF_LIMIT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RX_WINDOW     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OLD_PROTOCOL  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_T1_INITIAL    = 3'd4;

    // Reset values
    localparam logic [RetryW-1:0] RST_MAX_RETRIES   = 8'd10;
    localparam logic [15:0]       RST_BACKOFF_LIMIT = 16'd16;
    localparam logic [QlenW-1:0]  RST_RX_WINDOW     = 16'd2048;
    localparam logic [T1W-1:0]    RST_T1_INITIAL    = 24'd5000;

    localparam logic [RetryW-1:0] RETRY_MAX = 8'd255;
    localparam logic [T1W-1:0]    T1_MAX    = 24'hFFFFFF;

    // One result word
    typedef struct packed {
        logic [StateW-1:0] next_state;
        logic [FrameW-1:0] frame_kind;
        logic              start_t1;
        logic              stop_t3;
        logic [T1W-1:0]    t1_value;
        logic              flush_tx;
        logic              timed_out;
        logic              clear_response;
        logic              retransmitting;
    } t_result;

endpackage

// ===== design/lapb_t1_recovery.sv =====
// Top level: retry, backoff and timeout decisions of one LAPB link.
// Path: an accepted event enters the input register, then the result register.
// Throughput: one event per cycle unless the output stalls; retry count and
// T1 duration update with the result register, so the next event sees them.
// Input stall rises only when the input register is full and the output holds.
// Reset (synchronous, active low): retries 0, T1 5000, registers to defaults.
`timescale 1ns / 1ps

module lapb_t1_recovery (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // event channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [lapbt1_pkg::ModeW-1:0]     i_mode,
    input  logic [lapbt1_pkg::StateW-1:0]    i_link_state,
    input  logic [lapbt1_pkg::QlenW-1:0]     i_rx_queue_len,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [lapbt1_pkg::StateW-1:0]    o_next_state,
    output logic [lapbt1_pkg::FrameW-1:0]    o_frame_kind,
    output logic                             o_start_t1,
    output logic                             o_stop_t3,
    output logic [lapbt1_pkg::T1W-1:0]       o_t1_value,
    output logic                             o_flush_tx,
    output logic                             o_timed_out,
    output logic                             o_clear_response,
    output logic                             o_retransmitting,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lapbt1_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [lapbt1_pkg::CfgDatW-1:0]   i_cfg_data
);

    // Configuration registers
    logic [lapbt1_pkg::RetryW-1:0] r_max_retries;
    logic [15:0]                   r_backoff_limit;
    logic [lapbt1_pkg::QlenW-1:0]  r_rx_window;
    logic                          r_old_protocol;
    logic [lapbt1_pkg::T1W-1:0]    r_t1_initial;

    // Link timer state
    logic [lapbt1_pkg::RetryW-1:0] r_retry;
    logic [lapbt1_pkg::T1W-1:0]    r_t1;
    logic [lapbt1_pkg::RetryW-1:0] n_retry;
    logic [lapbt1_pkg::T1W-1:0]    n_t1;

    // Input register
    logic                          r_in_valid;
    logic [lapbt1_pkg::ModeW-1:0]  r_mode;
    logic [lapbt1_pkg::StateW-1:0] r_ls;
    logic [lapbt1_pkg::QlenW-1:0]  r_qlen;

    // Result register
    logic                          r_out_valid;
    lapbt1_pkg::t_result           r_res;
    lapbt1_pkg::t_result           n_res;

    logic out_free;
    logic move;
    logic take;

    // Handshake
    assign out_free    = !r_out_valid || !i_stall;
    assign move        = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign take        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries   <= lapbt1_pkg::RST_MAX_RETRIES;
            r_backoff_limit <= lapbt1_pkg::RST_BACKOFF_LIMIT;
            r_rx_window     <= lapbt1_pkg::RST_RX_WINDOW;
            r_old_protocol  <= 1'b0;
            r_t1_initial    <= lapbt1_pkg::RST_T1_INITIAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lapbt1_pkg::REG_MAX_RETRIES:   r_max_retries   <= i_cfg_data[7:0];
                lapbt1_pkg::REG_BACKOFF_LIMIT: r_backoff_limit <= i_cfg_data[15:0];
                lapbt1_pkg::REG_RX_WINDOW:     r_rx_window     <= i_cfg_data[15:0];
                lapbt1_pkg::REG_OLD_PROTOCOL:  r_old_protocol  <= i_cfg_data[0];
                lapbt1_pkg::REG_T1_INITIAL:    r_t1_initial    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decide the result and the next timer state for the registered event
    always_comb begin
        logic [lapbt1_pkg::RetryW-1:0] rc_inc;
        logic                          grow;
        logic [lapbt1_pkg::T1W:0]      dbl;
        logic [lapbt1_pkg::T1W-1:0]    t1_bo;
        logic                          hit;
        logic [lapbt1_pkg::FrameW-1:0] poll;

        rc_inc = (r_retry == lapbt1_pkg::RETRY_MAX) ? r_retry : r_retry + 8'd1;
        grow   = (rc_inc < 8'd16) &&
                 ((17'd1 << rc_inc[3:0]) < {1'b0, r_backoff_limit});
        dbl    = {r_t1, 1'b0};
        t1_bo  = !grow ? r_t1 :
                 (dbl[lapbt1_pkg::T1W] ? lapbt1_pkg::T1_MAX : dbl[lapbt1_pkg::T1W-1:0]);
        hit    = (r_max_retries != 8'd0) && (rc_inc > r_max_retries);
        poll   = (r_qlen >= r_rx_window) ? lapbt1_pkg::FR_RNR : lapbt1_pkg::FR_RR;

        n_retry = r_retry;
        n_t1    = r_t1;
        n_res   = '0;
        n_res.next_state = r_ls;

        unique case (r_mode)
            lapbt1_pkg::MODE_T1_EXP: begin
                n_retry = rc_inc;
                n_t1    = t1_bo;
                n_res.retransmitting = 1'b1;
                unique case (r_ls)
                    lapbt1_pkg::ST_SETUP: begin
                        if (hit) begin
                            n_res.flush_tx   = 1'b1;
                            n_res.timed_out  = 1'b1;
                            n_res.next_state = lapbt1_pkg::ST_DISC;
                        end else begin
                            n_res.frame_kind = lapbt1_pkg::FR_SABM;
                            n_res.start_t1   = 1'b1;
                        end
                    end
                    lapbt1_pkg::ST_DPEND: begin
                        if (hit) begin
                            n_res.timed_out  = 1'b1;
                            n_res.next_state = lapbt1_pkg::ST_DISC;
                        end else begin
                            n_res.frame_kind = lapbt1_pkg::FR_DISC;
                            n_res.start_t1   = 1'b1;
                        end
                    end
                    lapbt1_pkg::ST_CONN, lapbt1_pkg::ST_RECOV: begin
                        if (hit) begin
                            n_res.frame_kind = lapbt1_pkg::FR_DM;
                            n_res.flush_tx   = 1'b1;
                            n_res.timed_out  = 1'b1;
                            n_res.next_state = lapbt1_pkg::ST_DISC;
                        end else begin
                            n_res.frame_kind     = poll;
                            n_res.clear_response = 1'b1;
                            n_res.stop_t3        = 1'b1;
                            n_res.start_t1       = 1'b1;
                            n_res.next_state     = lapbt1_pkg::ST_RECOV;
                        end
                    end
                    default: ;
                endcase
            end
            lapbt1_pkg::MODE_T3_DUE: begin
                if (!r_old_protocol && r_ls == lapbt1_pkg::ST_CONN) begin
                    n_retry = '0;
                    n_res.frame_kind     = poll;
                    n_res.clear_response = 1'b1;
                    n_res.stop_t3        = 1'b1;
                    n_res.start_t1       = 1'b1;
                    n_res.next_state     = lapbt1_pkg::ST_RECOV;
                end
            end
            lapbt1_pkg::MODE_RESET: begin
                n_retry = '0;
                n_t1    = (r_t1_initial == '0) ? 24'd1 : r_t1_initial;
            end
            default: ;
        endcase

        n_res.t1_value = n_t1;
    end

    // Control: valid bits and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_retry     <= '0;
            r_t1        <= lapbt1_pkg::RST_T1_INITIAL;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_retry     <= n_retry;
                r_t1        <= n_t1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load input word, hold result while stalled
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode <= i_mode;
            r_ls   <= i_link_state;
            r_qlen <= i_rx_queue_len;
        end
        if (move) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_next_state     = r_res.next_state;
    assign o_frame_kind     = r_res.frame_kind;
    assign o_start_t1       = r_res.start_t1;
    assign o_stop_t3        = r_res.stop_t3;
    assign o_t1_value       = r_res.t1_value;
    assign o_flush_tx       = r_res.flush_tx;
    assign o_timed_out      = r_res.timed_out;
    assign o_clear_response = r_res.clear_response;
    assign o_retransmitting = r_res.retransmitting;

endmodule

// ===== design/lapbt1_chk.sv =====
// Port checker of the LAPB T1 recovery block and its bind.
`timescale 1ns / 1ps

module lapbt1_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [lapbt1_pkg::StateW-1:0] o_next_state,
    input logic [lapbt1_pkg::FrameW-1:0] o_frame_kind,
    input logic                          o_start_t1,
    input logic                          o_stop_t3,
    input logic [lapbt1_pkg::T1W-1:0]    o_t1_value,
    input logic                          o_flush_tx,
    input logic                          o_timed_out,
    input logic                          o_clear_response
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_kind) &&
                               $stable(o_t1_value) && $stable(o_next_state))
        else $error("stalled result changed");

    // A timeout always drops the link
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timed_out |-> o_next_state == lapbt1_pkg::ST_DISC &&
                                   !o_start_t1)
        else $error("timeout without disconnect");

    // A poll restarts T1, stops T3 and enters recovery
    a_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_kind == lapbt1_pkg::FR_RR ||
                    o_frame_kind == lapbt1_pkg::FR_RNR)
        |-> o_clear_response && o_start_t1 && o_stop_t3 &&
            o_next_state == lapbt1_pkg::ST_RECOV)
        else $error("poll without its actions");

    // Flush only on a timeout; T1 never zero
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_flush_tx || o_timed_out) && o_t1_value != '0)
        else $error("bad flush or zero T1");

endmodule

bind lapb_t1_recovery lapbt1_chk u_lapbt1_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_next_state     (o_next_state),
    .o_frame_kind     (o_frame_kind),
    .o_start_t1       (o_start_t1),
    .o_stop_t3        (o_stop_t3),
    .o_t1_value       (o_t1_value),
    .o_flush_tx       (o_flush_tx),
    .o_timed_out      (o_timed_out),
    .o_clear_response (o_clear_response)
);

// ===== tb/tb.sv =====
// Self-checking testbench of the LAPB T1 recovery block.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [lapbt1_pkg::ModeW-1:0]  mode;
        logic [lapbt1_pkg::StateW-1:0] link;
        logic [lapbt1_pkg::QlenW-1:0]  qlen;
    } t_event;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [lapbt1_pkg::ModeW-1:0]   i_mode = '0;
    logic [lapbt1_pkg::StateW-1:0]  i_link_state = '0;
    logic [lapbt1_pkg::QlenW-1:0]   i_rx_queue_len = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [lapbt1_pkg::StateW-1:0]  o_next_state;
    logic [lapbt1_pkg::FrameW-1:0]  o_frame_kind;
    logic                           o_start_t1;
    logic                           o_stop_t3;
    logic [lapbt1_pkg::T1W-1:0]     o_t1_value;
    logic                           o_flush_tx;
    logic                           o_timed_out;
    logic                           o_clear_response;
    logic                           o_retransmitting;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [lapbt1_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [lapbt1_pkg::CfgDatW-1:0] i_cfg_data = '0;

    // Mirror of the block's registers and retry state
    logic [lapbt1_pkg::RetryW-1:0]  cfg_max_retries = lapbt1_pkg::RST_MAX_RETRIES;
    logic [15:0]                    cfg_backoff = lapbt1_pkg::RST_BACKOFF_LIMIT;
    logic [lapbt1_pkg::QlenW-1:0]   cfg_rx_window = lapbt1_pkg::RST_RX_WINDOW;
    logic                           cfg_old_protocol = 1'b0;
    logic [lapbt1_pkg::T1W-1:0]     cfg_t1_initial = lapbt1_pkg::RST_T1_INITIAL;
    logic [lapbt1_pkg::RetryW-1:0]  retry_cnt = '0;
    logic [lapbt1_pkg::T1W-1:0]     t1_dur = lapbt1_pkg::RST_T1_INITIAL;

    t_event              event_q[$];
    lapbt1_pkg::t_result decision_q[$];
    int      mismatches = 0;
    int      pushed = 0;
    int      in_gap = 0;
    int      in_calm = 0;
    int      out_gap = 0;
    int      out_calm = 0;
    int      idle_cycles = 0;

    lapb_t1_recovery dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_link_state     (i_link_state),
        .i_rx_queue_len   (i_rx_queue_len),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_next_state     (o_next_state),
        .o_frame_kind     (o_frame_kind),
        .o_start_t1       (o_start_t1),
        .o_stop_t3        (o_stop_t3),
        .o_t1_value       (o_t1_value),
        .o_flush_tx       (o_flush_tx),
        .o_timed_out      (o_timed_out),
        .o_clear_response (o_clear_response),
        .o_retransmitting (o_retransmitting),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Work out the decision for one timer event and advance the retry state
    function automatic lapbt1_pkg::t_result recovery_decision(
            logic [lapbt1_pkg::ModeW-1:0] mode,
            logic [lapbt1_pkg::StateW-1:0] link,
            logic [lapbt1_pkg::QlenW-1:0] qlen);
        lapbt1_pkg::t_result          r;
        logic                         exhausted;
        logic [lapbt1_pkg::T1W:0]     dbl;
        logic                         poll;
        r = '0;
        r.next_state = link;
        poll = 1'b0;
        case (mode)
            lapbt1_pkg::MODE_T1_EXP: begin
                r.retransmitting = 1'b1;
                if (retry_cnt != lapbt1_pkg::RETRY_MAX)
                    retry_cnt = retry_cnt + 1'b1;
                // Back off only while 2^retries stays below the limit
                if (retry_cnt < 16 && (32'd1 << retry_cnt) < 32'(cfg_backoff)) begin
                    dbl = {t1_dur, 1'b0};
                    t1_dur = dbl[lapbt1_pkg::T1W] ? lapbt1_pkg::T1_MAX
                                                  : dbl[lapbt1_pkg::T1W-1:0];
                end
                exhausted = (cfg_max_retries != '0) && (retry_cnt > cfg_max_retries);
                case (link)
                    lapbt1_pkg::ST_SETUP: begin
                        if (exhausted) begin
                            r.flush_tx = 1'b1;
                            r.timed_out = 1'b1;
                            r.next_state = lapbt1_pkg::ST_DISC;
                        end else begin
                            r.frame_kind = lapbt1_pkg::FR_SABM;
                            r.start_t1 = 1'b1;
                        end
                    end
                    lapbt1_pkg::ST_DPEND: begin
                        if (exhausted) begin
                            r.timed_out = 1'b1;
                            r.next_state = lapbt1_pkg::ST_DISC;
                        end else begin
                            r.frame_kind = lapbt1_pkg::FR_DISC;
                            r.start_t1 = 1'b1;
                        end
                    end
                    lapbt1_pkg::ST_CONN, lapbt1_pkg::ST_RECOV: begin
                        if (exhausted) begin
                            r.frame_kind = lapbt1_pkg::FR_DM;
                            r.flush_tx = 1'b1;
                            r.timed_out = 1'b1;
                            r.next_state = lapbt1_pkg::ST_DISC;
                        end else begin
                            poll = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            lapbt1_pkg::MODE_T3_DUE: begin
                if (!cfg_old_protocol && link == lapbt1_pkg::ST_CONN) begin
                    retry_cnt = '0;
                    poll = 1'b1;
                end
            end
            lapbt1_pkg::MODE_RESET: begin
                retry_cnt = '0;
                t1_dur = (cfg_t1_initial == '0) ? lapbt1_pkg::T1W'(1) : cfg_t1_initial;
            end
            default: ;
        endcase
        if (poll) begin
            r.frame_kind = (qlen >= cfg_rx_window) ? lapbt1_pkg::FR_RNR : lapbt1_pkg::FR_RR;
            r.clear_response = 1'b1;
            r.stop_t3 = 1'b1;
            r.start_t1 = 1'b1;
            r.next_state = lapbt1_pkg::ST_RECOV;
        end
        r.t1_value = t1_dur;
        return r;
    endfunction

    // Pick an idle length: mostly short, a few long, with calm stretches
    task automatic next_idle(inout int calm, output int len);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            len = 0;
        end else if (r < 3) begin
            calm = $urandom_range(20, 80);
            len = 0;
        end else if (r < 55) begin
            len = 0;
        end else if (r < 85) begin
            len = $urandom_range(1, 3);
        end else if (r < 97) begin
            len = $urandom_range(4, 12);
        end else begin
            len = $urandom_range(20, 60);
        end
    endtask

    task automatic check_field(input string name, input logic [lapbt1_pkg::T1W-1:0] want,
                               input logic [lapbt1_pkg::T1W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: present queued events, predict each one as it is accepted
    always @(posedge i_clk) begin : drive
        logic   take;
        t_event ev;
        if (i_rst_n) begin
            take = i_valid && !o_stall;
            if (take) begin
                decision_q.push_back(recovery_decision(i_mode, i_link_state, i_rx_queue_len));
                next_idle(in_calm, in_gap);
            end
            if (!i_valid || take) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    ev = event_q.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= ev.mode;
                    i_link_state <= ev.link;
                    i_rx_queue_len <= ev.qlen;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest decision due
    always @(posedge i_clk) begin : watch
        lapbt1_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (decision_q.size() == 0) begin
                    $error("result word with no event pending");
                    mismatches++;
                end else begin
                    want = decision_q.pop_front();
                    check_field("next_state", lapbt1_pkg::T1W'(want.next_state),
                                lapbt1_pkg::T1W'(o_next_state));
                    check_field("frame_kind", lapbt1_pkg::T1W'(want.frame_kind),
                                lapbt1_pkg::T1W'(o_frame_kind));
                    check_field("start_t1", lapbt1_pkg::T1W'(want.start_t1),
                                lapbt1_pkg::T1W'(o_start_t1));
                    check_field("stop_t3", lapbt1_pkg::T1W'(want.stop_t3),
                                lapbt1_pkg::T1W'(o_stop_t3));
                    check_field("t1_value", want.t1_value, o_t1_value);
                    check_field("flush_tx", lapbt1_pkg::T1W'(want.flush_tx),
                                lapbt1_pkg::T1W'(o_flush_tx));
                    check_field("timed_out", lapbt1_pkg::T1W'(want.timed_out),
                                lapbt1_pkg::T1W'(o_timed_out));
                    check_field("clear_response", lapbt1_pkg::T1W'(want.clear_response),
                                lapbt1_pkg::T1W'(o_clear_response));
                    check_field("retransmitting", lapbt1_pkg::T1W'(want.retransmitting),
                                lapbt1_pkg::T1W'(o_retransmitting));
                end
                next_idle(out_calm, out_gap);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: drop the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lapb_t1_recovery");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_event(input logic [lapbt1_pkg::ModeW-1:0] mode,
                              input logic [lapbt1_pkg::StateW-1:0] link,
                              input logic [lapbt1_pkg::QlenW-1:0] qlen);
        event_q.push_back('{mode: mode, link: link, qlen: qlen});
        pushed++;
    endtask

    // Favor queue fills around the receive window edge
    function automatic logic [lapbt1_pkg::QlenW-1:0] pick_qlen();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return cfg_rx_window;
            3: return cfg_rx_window - 1'b1;
            default: return lapbt1_pkg::QlenW'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [lapbt1_pkg::CfgIdxW-1:0] idx,
                             input logic [lapbt1_pkg::CfgDatW-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            lapbt1_pkg::REG_MAX_RETRIES:   cfg_max_retries = data[lapbt1_pkg::RetryW-1:0];
            lapbt1_pkg::REG_BACKOFF_LIMIT: cfg_backoff = data[15:0];
            lapbt1_pkg::REG_RX_WINDOW:     cfg_rx_window = data[lapbt1_pkg::QlenW-1:0];
            lapbt1_pkg::REG_OLD_PROTOCOL:  cfg_old_protocol = data[0];
            lapbt1_pkg::REG_T1_INITIAL:    cfg_t1_initial = data[lapbt1_pkg::T1W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int max_retries, input int backoff, input int rx_window,
                              input int old_protocol, input int t1_initial);
        write_reg(lapbt1_pkg::REG_MAX_RETRIES, lapbt1_pkg::CfgDatW'(max_retries));
        write_reg(lapbt1_pkg::REG_BACKOFF_LIMIT, lapbt1_pkg::CfgDatW'(backoff));
        write_reg(lapbt1_pkg::REG_RX_WINDOW, lapbt1_pkg::CfgDatW'(rx_window));
        write_reg(lapbt1_pkg::REG_OLD_PROTOCOL, lapbt1_pkg::CfgDatW'(old_protocol));
        write_reg(lapbt1_pkg::REG_T1_INITIAL, lapbt1_pkg::CfgDatW'(t1_initial));
        @(negedge i_clk);
    endtask

    // Wait until every event is accepted and answered, then let the pipe settle
    task automatic drain();
        do
            @(negedge i_clk);
        while (event_q.size() != 0 || i_valid || decision_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Long run of T1 expiries so the retry count saturates
    task automatic saturate_retries(input int n);
        push_event(lapbt1_pkg::MODE_RESET, lapbt1_pkg::ST_DISC, pick_qlen());
        repeat (n) begin
            if ($urandom_range(0, 19) == 0)
                push_event(lapbt1_pkg::ModeW'($urandom_range(1, 3)),
                           lapbt1_pkg::StateW'($urandom_range(0, 2)), pick_qlen());
            else
                push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::StateW'($urandom),
                           pick_qlen());
        end
    endtask

    // Mostly well-formed link episodes, some noise and some broken runs
    task automatic gen_traffic(input int n);
        int target;
        int runs;
        int kind;
        target = pushed + n;
        while (pushed < target) begin
            kind = $urandom_range(0, 9);
            runs = $urandom_range(1, 4 + ((cfg_max_retries == '0 || cfg_max_retries > 16) ?
                                          16 : int'(cfg_max_retries)));
            if (kind < 6) begin
                push_event(lapbt1_pkg::MODE_RESET, lapbt1_pkg::StateW'($urandom_range(0, 4)),
                           pick_qlen());
                case ($urandom_range(0, 2))
                    0: repeat (runs) push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_SETUP,
                                                pick_qlen());
                    1: repeat (runs) push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_DPEND,
                                                pick_qlen());
                    default: begin
                        push_event(lapbt1_pkg::MODE_T3_DUE, lapbt1_pkg::ST_CONN, pick_qlen());
                        repeat (runs) begin
                            if ($urandom_range(0, 15) == 0)
                                push_event(lapbt1_pkg::MODE_T3_DUE, lapbt1_pkg::ST_CONN,
                                           pick_qlen());
                            else
                                push_event(lapbt1_pkg::MODE_T1_EXP,
                                           ($urandom_range(0, 3) == 0) ?
                                               lapbt1_pkg::ST_CONN : lapbt1_pkg::ST_RECOV,
                                           pick_qlen());
                        end
                    end
                endcase
            end else if (kind < 8) begin
                repeat (4) push_event(lapbt1_pkg::ModeW'($urandom),
                                      lapbt1_pkg::StateW'($urandom), pick_qlen());
            end else begin
                repeat (runs) push_event(lapbt1_pkg::MODE_T1_EXP,
                                         lapbt1_pkg::StateW'($urandom), pick_qlen());
            end
        end
    endtask

    initial begin : stimulus
        int mr;
        int bl;
        int rw;
        int t1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every frame kind but DM, undefined codes, setup timeout
        push_event(lapbt1_pkg::MODE_RESET, lapbt1_pkg::ST_DISC, '0);
        push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_SETUP, '0);
        push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_DPEND, '1);
        push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_CONN, 16'd2047);
        push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_RECOV, 16'd2048);
        push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_DISC, '1);
        push_event(lapbt1_pkg::MODE_T1_EXP, 3'd5, 16'h5555);
        push_event(lapbt1_pkg::MODE_T1_EXP, 3'd6, 16'hAAAA);
        push_event(lapbt1_pkg::MODE_T1_EXP, 3'd7, '0);
        push_event(2'd3, lapbt1_pkg::ST_CONN, '1);
        push_event(2'd3, 3'd7, '0);
        push_event(lapbt1_pkg::MODE_T3_DUE, lapbt1_pkg::ST_CONN, '1);
        push_event(lapbt1_pkg::MODE_T3_DUE, lapbt1_pkg::ST_SETUP, '0);
        repeat (11) push_event(lapbt1_pkg::MODE_T1_EXP, lapbt1_pkg::ST_SETUP, 16'd100);
        drain();

        // Retry forever, widest backoff, always not ready, saturating T1
        set_config(0, 65535, 0, 0, int'(lapbt1_pkg::T1_MAX));
        saturate_retries(260);
        gen_traffic(60);
        drain();

        // Limit 255, no backoff, ready below 65535, old protocol, zero initial T1
        set_config(255, 0, 65535, 1, 0);
        saturate_retries(260);
        gen_traffic(60);
        drain();

        // Tightest limits
        set_config(1, 1, $urandom_range(0, 65535), 0, 1);
        gen_traffic(60);
        drain();

        // Random settings
        repeat (3) begin
            case ($urandom_range(0, 3))
                0: mr = 0;
                1: mr = 255;
                default: mr = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 3))
                0: bl = $urandom_range(0, 1);
                1: bl = 65535;
                2: bl = $urandom_range(2, 64);
                default: bl = $urandom_range(1, 65535);
            endcase
            rw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0: t1 = $urandom_range(0, 1);
                1: t1 = $urandom_range(1, 16777215);
                default: t1 = $urandom_range(1, 20000);
            endcase
            set_config(mr, bl, rw, $urandom_range(0, 1), t1);
            gen_traffic(75);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS lapb_t1_recovery");
        else
            $display("FAIL lapb_t1_recovery");
        $finish;
    end

endmodule

// ===== lapb_t1_recovery.f =====
design/lapbt1_pkg.sv
design/lapb_t1_recovery.sv
design/lapbt1_chk.sv
tb/tb.sv
